// ===== sv/dnsl_pkg.sv =====
// package for the dns name table lookup block
// shared sizes, result codes and the query ring control struct; no dependencies
package dnsl_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int NAME_BYTES    = 128;

	localparam int IDX_W      = $clog2(TABLE_ENTRIES);
	localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
	localparam int POS_W      = $clog2(NAME_BYTES + 1);
	localparam int CELL_IDX_W = $clog2(NAME_BYTES);
	localparam int MEM_AW     = $clog2(TABLE_ENTRIES * NAME_BYTES);

	localparam logic [7:0] DOT_CHAR = 8'h2e;

	typedef enum logic [2:0] {
		OUT_FOUND    = 3'd0,
		OUT_BLOCKED  = 3'd1,
		OUT_RELAY    = 3'd2,
		OUT_INSERTED = 3'd3,
		OUT_FULL     = 3'd4
	} outcome_t;

	typedef struct packed {
		logic                  append;
		logic                  rotate;
		logic [CELL_IDX_W-1:0] wr_idx;
		logic [7:0]            wr_byte;
	} ring_ctrl_t;

endpackage

// ===== sv/dnsl_cell.sv =====
// one byte cell of the query ring
// loads a query character or takes its neighbour's byte on rotate; no dependencies
module dnsl_cell (
	input  logic       clk,
	input  logic       wr_en,
	input  logic       rot_en,
	input  logic [7:0] wr_byte,
	input  logic [7:0] nb_byte,
	output logic [7:0] q
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (rot_en) begin
			byte_q <= nb_byte;
		end else if (wr_en) begin
			byte_q <= wr_byte;
		end
	end

	assign q = byte_q;

endmodule

// ===== sv/dnsl_query_ring.sv =====
// query name buffer as a ring of byte cells
// depends on dnsl_pkg and dnsl_cell; cell 0 is the head seen by the compare stage
module dnsl_query_ring (
	input  logic                clk,
	input  dnsl_pkg::ring_ctrl_t ctrl,
	output logic [7:0]          head_byte
);

	logic [7:0] cell_q [dnsl_pkg::NAME_BYTES];

	for (genvar k = 0; k < dnsl_pkg::NAME_BYTES; k++) begin : g_cell
		dnsl_cell u_cell (
			.clk     (clk),
			.wr_en   (ctrl.append && (ctrl.wr_idx == dnsl_pkg::CELL_IDX_W'(k))),
			.rot_en  (ctrl.rotate),
			.wr_byte (ctrl.wr_byte),
			.nb_byte (cell_q[(k + 1) % dnsl_pkg::NAME_BYTES]),
			.q       (cell_q[k])
		);
	end

	assign head_byte = cell_q[0];

endmodule

// ===== sv/dns_name_table_lookup_top.sv =====
// dns name table lookup: inserts, wire-format query parsing and exact-match search
// one insert or non-terminal query byte per cycle while idle and the result register is free;
// a query terminator starts a scan that reads and checks each stored entry's length; an entry
// of equal length gets a full query ring turn of compare and a drain step; a final read ends a
// scan with no match; no requests taken meanwhile; empty or overlong names answer next cycle
// reset: control state and counters cleared; tables undefined until written, no clearing pass
module dns_name_table_lookup_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  name_byte,
	input  logic [31:0] ipv4_address,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  outcome,
	output logic [7:0]  entry_index,
	output logic [31:0] found_address
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LREAD,
		S_LCHECK,
		S_CMP,
		S_DRAIN
	} state_t;

	state_t state_q;

	logic [7:0]  names [dnsl_pkg::TABLE_ENTRIES * dnsl_pkg::NAME_BYTES];
	logic [dnsl_pkg::POS_W-1:0] lens [dnsl_pkg::TABLE_ENTRIES];
	logic [31:0] addrs [dnsl_pkg::TABLE_ENTRIES];

	logic [dnsl_pkg::CNT_W-1:0]      entries_q;
	logic [dnsl_pkg::POS_W-1:0]      ins_pos_q;
	logic [dnsl_pkg::MEM_AW-1:0]     ins_base_q;
	logic [dnsl_pkg::POS_W-1:0]      qlen_q;
	logic [7:0]                      label_q;
	logic                            ovf_q;
	logic [dnsl_pkg::POS_W-1:0]      slen_q;
	logic [dnsl_pkg::CNT_W-1:0]      idx_q;
	logic [dnsl_pkg::MEM_AW-1:0]     base_q;
	logic [dnsl_pkg::CELL_IDX_W-1:0] cnt_q;
	logic                            mismatch_q;
	logic                            out_valid_q;
	dnsl_pkg::outcome_t              outcome_q;
	logic [7:0]                      index_q;
	logic [31:0]                     res_addr_q;

	logic [7:0]                 name_rd_q;
	logic [dnsl_pkg::POS_W-1:0] len_rd_q;
	logic [31:0]                addr_rd_q;
	logic                       cmp_v_s1;
	logic                       cv_s1;
	logic [7:0]                 qb_s1;

	logic                       acc, full, ins_wr, q_append, q_store, q_finish, ok;
	logic                       cur_mis, out_free;
	logic [7:0]                 q_char, head_byte;
	logic [dnsl_pkg::POS_W-1:0] ins_len;
	logic [dnsl_pkg::MEM_AW-1:0] rd_addr;
	dnsl_pkg::ring_ctrl_t       ring_ctrl;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign acc      = in_valid && in_ready;
	assign full     = entries_q >= dnsl_pkg::CNT_W'(dnsl_pkg::TABLE_ENTRIES);
	assign ins_wr   = acc && !func && !full && (ins_pos_q < dnsl_pkg::POS_W'(dnsl_pkg::NAME_BYTES));
	assign ins_len  = ins_wr ? ins_pos_q + dnsl_pkg::POS_W'(1) : ins_pos_q;

	// length bytes after the first label turn into dots
	assign q_append = acc && func && ((label_q != 8'd0) ||
		((name_byte != 8'd0) && ((qlen_q != '0) || ovf_q)));
	assign q_store  = q_append && (qlen_q < dnsl_pkg::POS_W'(dnsl_pkg::NAME_BYTES));
	assign q_char   = (label_q != 8'd0) ? name_byte : dnsl_pkg::DOT_CHAR;
	assign q_finish = acc && func && (label_q == 8'd0) && (name_byte == 8'd0);
	assign ok       = !ovf_q && (qlen_q != '0);

	assign rd_addr  = base_q + dnsl_pkg::MEM_AW'(cnt_q);
	assign cur_mis  = cmp_v_s1 && cv_s1 && (name_rd_q != qb_s1);

	always_comb begin
		ring_ctrl.append  = q_store;
		ring_ctrl.rotate  = (state_q == S_CMP);
		ring_ctrl.wr_idx  = qlen_q[dnsl_pkg::CELL_IDX_W-1:0];
		ring_ctrl.wr_byte = q_char;
	end

	dnsl_query_ring u_ring (
		.clk       (clk),
		.ctrl      (ring_ctrl),
		.head_byte (head_byte)
	);

	always_ff @(posedge clk) begin
		if (ins_wr) begin
			names[ins_base_q + dnsl_pkg::MEM_AW'(ins_pos_q)] <= name_byte;
		end
		if (acc && !func && !full && final_byte) begin
			lens[entries_q[dnsl_pkg::IDX_W-1:0]]  <= ins_len;
			addrs[entries_q[dnsl_pkg::IDX_W-1:0]] <= ipv4_address;
		end
		name_rd_q <= names[rd_addr];
		len_rd_q  <= lens[idx_q[dnsl_pkg::IDX_W-1:0]];
		addr_rd_q <= addrs[idx_q[dnsl_pkg::IDX_W-1:0]];
		qb_s1     <= head_byte;
		cv_s1     <= dnsl_pkg::POS_W'(cnt_q) < slen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			entries_q   <= '0;
			ins_pos_q   <= '0;
			ins_base_q  <= '0;
			qlen_q      <= '0;
			label_q     <= 8'd0;
			ovf_q       <= 1'b0;
			slen_q      <= '0;
			idx_q       <= '0;
			base_q      <= '0;
			cnt_q       <= '0;
			mismatch_q  <= 1'b0;
			cmp_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			outcome_q   <= dnsl_pkg::OUT_RELAY;
			index_q     <= 8'd0;
			res_addr_q  <= 32'd0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			cmp_v_s1 <= (state_q == S_CMP);
			case (state_q)
				S_IDLE: begin
					if (acc && !func) begin
						if (full) begin
							ins_pos_q <= '0;
							if (final_byte) begin
								out_valid_q <= 1'b1;
								outcome_q   <= dnsl_pkg::OUT_FULL;
								index_q     <= 8'd0;
								res_addr_q  <= 32'd0;
							end
						end else if (final_byte) begin
							out_valid_q <= 1'b1;
							outcome_q   <= dnsl_pkg::OUT_INSERTED;
							index_q     <= 8'(entries_q);
							res_addr_q  <= 32'd0;
							entries_q   <= entries_q + dnsl_pkg::CNT_W'(1);
							ins_base_q  <= ins_base_q + dnsl_pkg::MEM_AW'(dnsl_pkg::NAME_BYTES);
							ins_pos_q   <= '0;
						end else begin
							ins_pos_q <= ins_len;
						end
					end
					if (q_append) begin
						if (q_store) begin
							qlen_q <= qlen_q + dnsl_pkg::POS_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					if (acc && func) begin
						if (label_q != 8'd0) begin
							label_q <= label_q - 8'd1;
						end else if (name_byte != 8'd0) begin
							label_q <= name_byte;
						end
					end
					if (q_finish) begin
						qlen_q <= '0;
						ovf_q  <= 1'b0;
						slen_q <= qlen_q;
						idx_q  <= '0;
						base_q <= '0;
						cnt_q  <= '0;
						if (ok) begin
							state_q <= S_LREAD;
						end else begin
							out_valid_q <= 1'b1;
							outcome_q   <= dnsl_pkg::OUT_RELAY;
							index_q     <= 8'd0;
							res_addr_q  <= 32'd0;
						end
					end
				end
				S_LREAD: begin
					if (idx_q >= entries_q) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						outcome_q   <= dnsl_pkg::OUT_RELAY;
						index_q     <= 8'd0;
						res_addr_q  <= 32'd0;
					end else begin
						state_q <= S_LCHECK;
					end
				end
				S_LCHECK: begin
					if (len_rd_q == slen_q) begin
						state_q    <= S_CMP;
						cnt_q      <= '0;
						mismatch_q <= 1'b0;
					end else begin
						idx_q   <= idx_q + dnsl_pkg::CNT_W'(1);
						base_q  <= base_q + dnsl_pkg::MEM_AW'(dnsl_pkg::NAME_BYTES);
						state_q <= S_LREAD;
					end
				end
				S_CMP: begin
					mismatch_q <= mismatch_q | cur_mis;
					if (cnt_q == dnsl_pkg::CELL_IDX_W'(dnsl_pkg::NAME_BYTES - 1)) begin
						state_q <= S_DRAIN;
					end
					cnt_q <= (cnt_q == dnsl_pkg::CELL_IDX_W'(dnsl_pkg::NAME_BYTES - 1)) ?
						'0 : cnt_q + dnsl_pkg::CELL_IDX_W'(1);
				end
				S_DRAIN: begin
					// ring is back in line after a full turn
					if (!(mismatch_q | cur_mis)) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						index_q     <= 8'(idx_q);
						res_addr_q  <= addr_rd_q;
						outcome_q   <= (addr_rd_q == 32'd0) ? dnsl_pkg::OUT_BLOCKED :
							dnsl_pkg::OUT_FOUND;
					end else begin
						idx_q   <= idx_q + dnsl_pkg::CNT_W'(1);
						base_q  <= base_q + dnsl_pkg::MEM_AW'(dnsl_pkg::NAME_BYTES);
						state_q <= S_LREAD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign outcome       = 3'(outcome_q);
	assign entry_index   = index_q;
	assign found_address = res_addr_q;

	a_entries_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entries_q <= dnsl_pkg::CNT_W'(dnsl_pkg::TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_qlen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qlen_q <= dnsl_pkg::POS_W'(dnsl_pkg::NAME_BYTES))
		else $error("query length beyond buffer size");

	a_relay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (outcome_q == dnsl_pkg::OUT_RELAY) |-> (index_q == 8'd0) &&
		(res_addr_q == 32'd0))
		else $error("relay result carries index or address");

	a_cmp_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (slen_q != '0) && !out_valid_q)
		else $error("compare running on empty name or with pending result");

endmodule
